// ===== sv/cdtt_pkg.sv =====
// Shared constants and calendar helper functions for calendar_difference_to_ticks.
package cdtt_pkg;

  // Field widths of one timestamp
  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned ClockW  = 17;
  localparam int unsigned MillisW = 10;
  localparam int unsigned StampW  = YearW + MonthW + DayW + ClockW + MillisW;

  // Stream payload widths (input padded to whole bytes)
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned RateW    = 32;

  // Day number since 2000-01-00 and seconds of day
  localparam int unsigned DayNumW = 16;
  localparam int unsigned SodW    = 17;

  // Year offset of 2100, the only non-leap multiple of four in range
  localparam logic [YearW-1:0] NonLeapCentury = 7'd100;

  // rate / 1000 as (rate * DivMul1000) >> 38, low by at most one
  localparam logic [28:0] DivMul1000  = 29'd274877906;
  // x / 1000 for x below 2^20, exact as (x * SmallDivMul) >> 30
  localparam logic [20:0] SmallDivMul = 21'd1073742;

  localparam int unsigned SecsW = 35;

  // Days before the first of the month; month 0 reads as January,
  // months past December read as December.
  function automatic logic [8:0] days_before_month(logic [MonthW-1:0] month);
    logic [8:0] days;
    case (month) inside
      4'd0, 4'd1:     days = 9'd0;
      4'd2:           days = 9'd31;
      4'd3:           days = 9'd59;
      4'd4:           days = 9'd90;
      4'd5:           days = 9'd120;
      4'd6:           days = 9'd151;
      4'd7:           days = 9'd181;
      4'd8:           days = 9'd212;
      4'd9:           days = 9'd243;
      4'd10:          days = 9'd273;
      4'd11:          days = 9'd304;
      [4'd12:4'd15]:  days = 9'd334;
      default:        days = 9'd334;
    endcase
    return days;
  endfunction

  // Days since 2000-01-00 (day field used as given, may run past month end)
  function automatic logic [DayNumW-1:0] day_number(logic [YearW-1:0]  year,
                                                    logic [MonthW-1:0] month,
                                                    logic [DayW-1:0]   day);
    logic [DayNumW-1:0] base;
    logic [7:0]         year_p3;
    logic [5:0]         leaps;
    logic               leap;
    logic               past_feb;
    base     = DayNumW'({9'd0, year}) * 16'd365;
    year_p3  = {1'b0, year} + 8'd3;
    // leap years in [2000, year-1]: every fourth one except 2100
    leaps    = year_p3[7:2] - {5'd0, (year > NonLeapCentury)};
    leap     = (year[1:0] == 2'b00) && (year != NonLeapCentury);
    past_feb = (month >= 4'd3);
    return base + {10'd0, leaps} + {7'd0, days_before_month(month)}
         + {15'd0, leap && past_feb} + {11'd0, day};
  endfunction

  // hour in [16:12], minute in [11:6], second in [5:0]
  function automatic logic [SodW-1:0] secs_of_day(logic [ClockW-1:0] clock);
    return SodW'(clock[16:12]) * 17'd3600 + SodW'(clock[11:6]) * 17'd60
         + SodW'(clock[5:0]);
  endfunction

endpackage

// ===== sv/calendar_difference_to_ticks.sv =====
// Top level: timestamp pair difference scaled to ticks, seven-stage pipeline.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: cur and ref timestamps
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: elapsed_ticks, tuser: not_later
// cfg       in         cfg_we_i (no wait)           cfg_wdata_i: ticks per second
//
// One item per cycle sustained over seven register stages while m_axis does
// not stall; an accepted item passes stages 1 to 6 into the output register. The
// depth is set by the 32x32 seconds-by-rate product and the two reciprocal
// multiplications that stand in for the divisions by 1000.
// Every stage holds its own valid bit and moves when the stage after it is
// empty or moving, so bubbles close up and a stall at m_axis loses nothing.
// Reset clears the valid bits and loads the ticks-per-second register with 1000.
module calendar_difference_to_ticks (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: ticks per second, written when cfg_we_i is high
  input  logic                            cfg_we_i,
  input  logic [cdtt_pkg::RateW-1:0]      cfg_wdata_i,
  // Input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // cur_year, cur_month, cur_day, cur_clock, cur_millis,
  // ref_year, ref_month, ref_day, ref_clock, ref_millis, 2 zero bits
  input  logic [cdtt_pkg::InDataW-1:0]    s_axis_tdata,
  // Result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // elapsed_ticks
  output logic [cdtt_pkg::OutDataW-1:0]   m_axis_tdata,
  // not_later
  output logic                            m_axis_tuser
);

  localparam int unsigned NStages = 7;

  logic [cdtt_pkg::RateW-1:0] ticks_per_sec_q;
  logic [NStages-1:0]         valid_q;
  logic [NStages-1:0]         adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_sec_q <= 32'd1000;
    end else if (cfg_we_i) begin
      ticks_per_sec_q <= cfg_wdata_i;
    end
  end

  // Stage advance chain, output end first
  always_comb begin
    adv[NStages-1] = !valid_q[NStages-1] || m_axis_tready;
    for (int k = NStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: unpack, order compare, day numbers, seconds of day,
  // millisecond distance, first estimate of rate / 1000
  // ---------------------------------------------------------------------
  logic [cdtt_pkg::StampW-1:0] cur_key, ref_key;
  logic [6:0]  cur_year, ref_year;
  logic [3:0]  cur_month, ref_month;
  logic [4:0]  cur_day, ref_day;
  logic [16:0] cur_clock, ref_clock;
  logic [9:0]  cur_millis, ref_millis;

  assign cur_year   = s_axis_tdata[6:0];
  assign cur_month  = s_axis_tdata[10:7];
  assign cur_day    = s_axis_tdata[15:11];
  assign cur_clock  = s_axis_tdata[32:16];
  assign cur_millis = s_axis_tdata[42:33];
  assign ref_year   = s_axis_tdata[49:43];
  assign ref_month  = s_axis_tdata[53:50];
  assign ref_day    = s_axis_tdata[58:54];
  assign ref_clock  = s_axis_tdata[75:59];
  assign ref_millis = s_axis_tdata[85:76];

  // Lexicographic order on raw fields equals order on the concatenation
  assign cur_key = {cur_year, cur_month, cur_day, cur_clock, cur_millis};
  assign ref_key = {ref_year, ref_month, ref_day, ref_clock, ref_millis};

  logic                          nl1_d, nl1_q;
  logic [cdtt_pkg::DayNumW-1:0]  dnc1_d, dnc1_q, dnr1_d, dnr1_q;
  logic [cdtt_pkg::SodW-1:0]     sodc1_d, sodc1_q, sodr1_d, sodr1_q;
  logic [9:0]                    msabs1_d, msabs1_q;
  logic [60:0]                   rate_prod;
  logic [22:0]                   q0_1_d, q0_1_q;
  logic [cdtt_pkg::RateW-1:0]    rate1_q;

  always_comb begin
    nl1_d     = !(cur_key > ref_key);
    dnc1_d    = cdtt_pkg::day_number(cur_year, cur_month, cur_day);
    dnr1_d    = cdtt_pkg::day_number(ref_year, ref_month, ref_day);
    sodc1_d   = cdtt_pkg::secs_of_day(cur_clock);
    sodr1_d   = cdtt_pkg::secs_of_day(ref_clock);
    msabs1_d  = (cur_millis >= ref_millis) ? (cur_millis - ref_millis)
                                           : (ref_millis - cur_millis);
    rate_prod = 61'(ticks_per_sec_q) * 61'(cdtt_pkg::DivMul1000);
    q0_1_d    = rate_prod[60:38];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      nl1_q    <= nl1_d;
      dnc1_q   <= dnc1_d;
      dnr1_q   <= dnr1_d;
      sodc1_q  <= sodc1_d;
      sodr1_q  <= sodr1_d;
      msabs1_q <= msabs1_d;
      q0_1_q   <= q0_1_d;
      rate1_q  <= ticks_per_sec_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: signed second count, remainder of the rate estimate
  // ---------------------------------------------------------------------
  logic [16:0]                        day_diff;
  logic [17:0]                        sod_diff;
  logic signed [cdtt_pkg::SecsW-1:0]  secs2_d, secs2_q;
  logic [32:0]                        rem_full;
  logic [10:0]                        rraw2_q;
  logic [22:0]                        q0_2_q;
  logic [9:0]                         msabs2_q;
  logic [cdtt_pkg::RateW-1:0]         rate2_q;
  logic                               nl2_q;

  always_comb begin
    day_diff = {1'b0, dnc1_q} - {1'b0, dnr1_q};
    sod_diff = {1'b0, sodc1_q} - {1'b0, sodr1_q};
    secs2_d  = $signed({{18{day_diff[16]}}, day_diff}) * $signed(35'sd86400)
             + $signed({{17{sod_diff[17]}}, sod_diff});
    rem_full = {1'b0, rate1_q} - 33'(q0_1_q) * 33'd1000;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      secs2_q  <= secs2_d;
      rraw2_q  <= rem_full[10:0];
      q0_2_q   <= q0_1_q;
      msabs2_q <= msabs1_q;
      rate2_q  <= rate1_q;
      nl2_q    <= nl1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: correct rate = 1000 * qt + rt, magnitude and sign of seconds
  // ---------------------------------------------------------------------
  logic                         wrap;
  logic [10:0]                  rt_full;
  logic [cdtt_pkg::SecsW-1:0]   secs_neg;
  logic [22:0]                  qt3_d, qt3_q;
  logic [9:0]                   rt3_q;
  logic [31:0]                  sabs3_d, sabs3_q;
  logic                         sneg3_q;
  logic [9:0]                   msabs3_q;
  logic [cdtt_pkg::RateW-1:0]   rate3_q;
  logic                         nl3_q;

  always_comb begin
    wrap     = (rraw2_q >= 11'd1000);
    qt3_d    = wrap ? (q0_2_q + 23'd1) : q0_2_q;
    rt_full  = wrap ? (rraw2_q - 11'd1000) : rraw2_q;
    secs_neg = -secs2_q;
    sabs3_d  = secs2_q[cdtt_pkg::SecsW-1] ? secs_neg[31:0] : secs2_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      qt3_q    <= qt3_d;
      rt3_q    <= rt_full[9:0];
      sabs3_q  <= sabs3_d;
      sneg3_q  <= secs2_q[cdtt_pkg::SecsW-1];
      msabs3_q <= msabs2_q;
      rate3_q  <= rate2_q;
      nl3_q    <= nl2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: products; ms term = msabs*qt + floor(msabs*rt / 1000)
  // ---------------------------------------------------------------------
  logic [63:0] part4_q;
  logic [32:0] mq4_q;
  logic [19:0] mr4_q;
  logic        sneg4_q, nl4_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      part4_q <= 64'(sabs3_q) * 64'(rate3_q);
      mq4_q   <= 33'(msabs3_q) * 33'(qt3_q);
      mr4_q   <= 20'(msabs3_q) * 20'(rt3_q);
      sneg4_q <= sneg3_q;
      nl4_q   <= nl3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: reciprocal product for the small division by 1000
  // ---------------------------------------------------------------------
  logic [40:0] mrq5_q;
  logic [63:0] part5_q;
  logic [32:0] mq5_q;
  logic        sneg5_q, nl5_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      mrq5_q  <= 41'(mr4_q) * 41'(cdtt_pkg::SmallDivMul);
      part5_q <= part4_q;
      mq5_q   <= mq4_q;
      sneg5_q <= sneg4_q;
      nl5_q   <= nl4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: millisecond term
  // ---------------------------------------------------------------------
  logic [32:0] msterm6_q;
  logic [63:0] part6_q;
  logic        sneg6_q, nl6_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      msterm6_q <= mq5_q + {23'd0, mrq5_q[39:30]};
      part6_q   <= part5_q;
      sneg6_q   <= sneg5_q;
      nl6_q     <= nl5_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7 (output register): zero when not later, else signed combine with
  // saturation at all ones and clamp at zero
  // ---------------------------------------------------------------------
  logic [64:0] sum_pos;
  logic [63:0] ms64;
  logic [63:0] ticks7_d, ticks7_q;
  logic        nl7_q;

  always_comb begin
    ms64    = 64'(msterm6_q);
    sum_pos = {1'b0, part6_q} + {1'b0, ms64};
    if (nl6_q) begin
      ticks7_d = '0;
    end else if (!sneg6_q) begin
      ticks7_d = sum_pos[64] ? '1 : sum_pos[63:0];
    end else begin
      ticks7_d = (ms64 > part6_q) ? (ms64 - part6_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      ticks7_q <= ticks7_d;
      nl7_q    <= nl6_q;
    end
  end

  assign m_axis_tvalid = valid_q[NStages-1];
  assign m_axis_tdata  = ticks7_q;
  assign m_axis_tuser  = nl7_q;

endmodule
